@@ design/tdrr_pkg.sv @@
// -----------------------------------------------------------------------------
// tdrr_pkg
// Shared widths and constants for the tooth duration ring recorder.
// -----------------------------------------------------------------------------
package tdrr_pkg;

   localparam int SPEED_W    = 16;
   localparam int DUR_IN_W   = 32;
   localparam int DUR_W      = 19;
   localparam int SLOT_W     = 4;
   localparam int FILL_W     = 8;
   localparam int THR_W      = 8;
   localparam int THR_SCL_W  = 12;

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 2;

   localparam logic [DUR_W-1:0]    DUR_MAX  = 19'd500000;
   localparam logic [DUR_IN_W-1:0] DUR_CAP  = 32'd500000;
   localparam logic [FILL_W-1:0]   FILL_MAX = 8'd255;

   // Tooth event flags as carried in req_tuser.
   typedef struct packed {
      logic sync_fault;
      logic backup_signal;
      logic diag_resync;
   } tdrr_flags_type;

   // Threshold in rpm: 10 * value, built from two shifts.
   function automatic logic [THR_SCL_W-1:0] scale_threshold(input logic [THR_W-1:0] thr);
      logic [THR_SCL_W-1:0] t;
      begin
         t = {{(THR_SCL_W-THR_W){1'b0}}, thr};
         scale_threshold = (t << 3) + (t << 1);
      end
   endfunction

endpackage

@@ design/tdrr_ring.sv @@
// -----------------------------------------------------------------------------
// tdrr_ring
// Duration ring storage with one write port and one read port; the read sees
// the write of the same cycle. Slots at or beyond the depth read as zero.
// -----------------------------------------------------------------------------
module tdrr_ring #(
   parameter int DEPTH = 12,
   parameter int IDX_W = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_idx,
   input  logic [tdrr_pkg::DUR_W-1:0]  wr_data,
   input  logic [tdrr_pkg::SLOT_W-1:0] rd_slot,
   output logic [tdrr_pkg::DUR_W-1:0]  rd_data
);
   import tdrr_pkg::*;

   localparam int SEL_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam logic [SEL_W:0] DEPTH_V = (SEL_W+1)'(DEPTH);

   logic [DUR_W-1:0] ring_ff [DEPTH];
   logic [SEL_W:0]   slot_ext;
   logic [IDX_W-1:0] slot_idx;
   logic             slot_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            ring_ff[i] <= DUR_MAX;
         end
      end else if (wr_en) begin
         ring_ff[wr_idx] <= wr_data;
      end
   end

   assign slot_ext = {{(SEL_W+1-SLOT_W){1'b0}}, rd_slot};
   assign slot_ok  = slot_ext < DEPTH_V;
   assign slot_idx = slot_ext[IDX_W-1:0];

   always_comb begin
      if (!slot_ok) begin
         rd_data = '0;
      end else if (wr_en && (wr_idx == slot_idx)) begin
         rd_data = wr_data;
      end else begin
         rd_data = ring_ff[slot_idx];
      end
   end

endmodule

@@ design/tooth_duration_ring_recorder.sv @@
// -----------------------------------------------------------------------------
// tooth_duration_ring_recorder
// Records crank tooth durations in a ring while engine speed is at or below a
// programmable threshold, and reports enable, activation, newest index, fill
// count and one selected ring entry per tooth event.
// -----------------------------------------------------------------------------
// Path: an accepted request goes into the input register, then the update
//   into the response register.
// Throughput: one request per cycle while rsp_tready does not stall the response;
//   the state update is a single compare, one ring write and a counter step
//   between the two registers.
// Reset: synchronous, active high; ring entries return to 500000, index,
//   counters and the threshold to zero. No clearing pass is needed.
module tooth_duration_ring_recorder #(
   parameter int DEPTH = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   // Configuration: speed_threshold
   input  logic                            csr_wr_en,
   input  logic [tdrr_pkg::THR_W-1:0]      csr_wr_data,
   // Requests
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] engine_speed, [47:16] tooth_duration, [51:48] read_slot, [55:52] zero
   input  logic [tdrr_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] diag_resync, [1] backup_signal, [2] sync_fault
   input  logic [tdrr_pkg::REQ_USER_W-1:0] req_tuser,
   // Responses
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [3:0] newest_index, [11:4] fill_count, [30:12] read_duration, [31] zero
   output logic [tdrr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] calc_enabled, [1] calc_activated
   output logic [tdrr_pkg::RSP_USER_W-1:0] rsp_tuser
);
   import tdrr_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SEL_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

   // Threshold, pre-scaled to rpm on write
   logic [THR_SCL_W-1:0] thr_rpm_ff;

   // Input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [SPEED_W-1:0]   s1_speed_ff;
   logic [DUR_IN_W-1:0]  s1_dur_ff;
   logic [SLOT_W-1:0]    s1_slot_ff;
   tdrr_flags_type       s1_flags_ff;

   // Recorder state
   logic [IDX_W-1:0]     wr_idx_ff, wr_idx_in;
   logic                 en_prev_ff, en_prev_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic                 rc_prev_ff, rc_prev_in;

   // Response register
   logic                 out_valid_ff, out_valid_in;
   logic                 out_en_ff, out_act_ff;
   logic [SLOT_W-1:0]    out_idx_ff;
   logic [FILL_W-1:0]    out_fill_ff;
   logic [DUR_W-1:0]     out_dur_ff;

   // Update logic
   logic                 s1_move;
   logic                 req_take;
   logic                 enabled, activated, reset_cond;
   logic                 ring_we;
   logic [DUR_W-1:0]     dur_sat;
   logic [DUR_W-1:0]     rd_dur;
   logic [SEL_W-1:0]     idx_ext;

   // Advance stage 1 whenever the response register is free or being drained.
   assign s1_move      = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !s1_valid_ff || s1_move;
   assign req_take     = req_tvalid && req_tready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_rpm_ff <= '0;
      end else if (csr_wr_en) begin
         thr_rpm_ff <= scale_threshold(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the request payload while stage 1 is stalled.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_speed_ff <= req_tdata[15:0];
         s1_dur_ff   <= req_tdata[47:16];
         s1_slot_ff  <= req_tdata[51:48];
         s1_flags_ff <= tdrr_flags_type'({req_tuser[2], req_tuser[1], req_tuser[0]});
      end
   end

   // Enable compare, activation edge and saturation of the stored duration.
   assign enabled    = {{(THR_SCL_W > SPEED_W ? 0 : SPEED_W-THR_SCL_W){1'b0}}, thr_rpm_ff}
                       >= s1_speed_ff;
   assign activated  = enabled && !en_prev_ff;
   assign reset_cond = activated || s1_flags_ff.diag_resync
                       || s1_flags_ff.sync_fault || s1_flags_ff.backup_signal;
   assign dur_sat    = (s1_dur_ff > DUR_CAP) ? DUR_MAX : s1_dur_ff[DUR_W-1:0];
   assign ring_we    = s1_move && enabled;

   always_comb begin
      wr_idx_in  = wr_idx_ff;
      en_prev_in = en_prev_ff;
      fill_in    = fill_ff;
      rc_prev_in = rc_prev_ff;
      if (s1_move) begin
         en_prev_in = enabled;
         if (enabled) begin
            // Advance the write slot, wrapping at the ring depth.
            wr_idx_in = (wr_idx_ff >= IDX_LAST) ? '0 : wr_idx_ff + 1'b1;
            if (reset_cond) begin
               // Clear on the first item of a reset run, hold for the rest.
               if (!rc_prev_ff) begin
                  fill_in = '0;
               end
               rc_prev_in = 1'b1;
            end else begin
               rc_prev_in = 1'b0;
               if (fill_ff != FILL_MAX) begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff  <= '0;
         en_prev_ff <= 1'b0;
         fill_ff    <= '0;
         rc_prev_ff <= 1'b0;
      end else begin
         wr_idx_ff  <= wr_idx_in;
         en_prev_ff <= en_prev_in;
         fill_ff    <= fill_in;
         rc_prev_ff <= rc_prev_in;
      end
   end

   // Ring storage; the read returns the entry after this item's write.
   tdrr_ring #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ring_we),
      .wr_idx  (wr_idx_in),
      .wr_data (dur_sat),
      .rd_slot (s1_slot_ff),
      .rd_data (rd_dur)
   );

   assign idx_ext = {{(SEL_W-IDX_W){1'b0}}, wr_idx_in};

   // Capture the response; drop the fill count to zero while disabled.
   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_en_ff   <= enabled;
         out_act_ff  <= activated;
         out_idx_ff  <= idx_ext[SLOT_W-1:0];
         out_fill_ff <= enabled ? fill_in : '0;
         out_dur_ff  <= rd_dur;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_dur_ff, out_fill_ff, out_idx_ff};
   assign rsp_tuser  = {out_act_ff, out_en_ff};

endmodule
